// ----- rtl/three_queue_phased_task_dispatcher_macros.svh -----
// Assertion macros for the three-queue phased task dispatcher.
`ifndef THREE_QUEUE_PHASED_TASK_DISPATCHER_MACROS_SVH
`define THREE_QUEUE_PHASED_TASK_DISPATCHER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off while reset is asserted.
`define TQD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dispatcher check failed: same-cycle rule");

// Next-cycle implication, held off while reset is asserted.
`define TQD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dispatcher check failed: next-cycle rule");

`else

`define TQD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TQD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/tqd_pkg.sv -----
// Shared types and constants for the three-queue phased task dispatcher.
package tqd_pkg;

    localparam int ACTION_W = 3;
    localparam int TASK_W   = 8;
    localparam int PHASE_W  = 3;

    localparam logic [ACTION_W-1:0] ACT_PUSH_SLOW   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_MEDIUM = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PUSH_FAST   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PUSH_PAIR   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TICK_SLOW   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_TICK_MEDIUM = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_TICK_FAST   = 3'd6;

    // controller -> datapath
    typedef struct packed {
        logic load_item;    // capture the input transaction
        logic execute;      // decide, first write / pop, phase step
        logic write_second; // second write of a fast pair
        logic load_result;  // move result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pair_go;      // pair push has room, second write needed
    } t_sts;

endpackage

// ----- rtl/tqd_ctrl.sv -----
// Sequencing state machine of the dispatcher: handshakes and datapath commands.
module tqd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  tqd_pkg::t_sts i_sts,
    output tqd_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_PAIR   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign out_free   = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = i_sts.pair_go ? S_PAIR : S_RESULT;
            end
            S_PAIR: begin
                o_cmd.write_second = 1'b1;
                n_state            = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/tqd_dp.sv -----
// Dispatcher datapath: three circular queues, phase counters, result register.
module tqd_dp #(
    parameter int SLOW_DEPTH   = 16,
    parameter int MEDIUM_DEPTH = 16,
    parameter int FAST_DEPTH   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tqd_pkg::t_cmd               i_cmd,
    output tqd_pkg::t_sts               o_sts,
    input  logic [tqd_pkg::ACTION_W-1:0] i_action,
    input  logic [tqd_pkg::TASK_W-1:0]   i_task_req,
    input  logic [tqd_pkg::TASK_W-1:0]   i_second_task,
    output logic                        o_refused,
    output logic                        o_dispatched,
    output logic [tqd_pkg::TASK_W-1:0]   o_dispatched_task
);

    localparam int SW = $clog2(SLOW_DEPTH);
    localparam int MW = $clog2(MEDIUM_DEPTH);
    localparam int FW = $clog2(FAST_DEPTH);

    logic [tqd_pkg::TASK_W-1:0] r_slow_mem   [SLOW_DEPTH];
    logic [tqd_pkg::TASK_W-1:0] r_medium_mem [MEDIUM_DEPTH];
    logic [tqd_pkg::TASK_W-1:0] r_fast_mem   [FAST_DEPTH];

    logic [tqd_pkg::ACTION_W-1:0] r_action;
    logic [tqd_pkg::TASK_W-1:0]   r_task1;
    logic [tqd_pkg::TASK_W-1:0]   r_task2;

    logic [SW-1:0] r_slow_head, r_slow_tail, n_slow_head, n_slow_tail;
    logic [MW-1:0] r_medium_head, r_medium_tail, n_medium_head, n_medium_tail;
    logic [FW-1:0] r_fast_head, r_fast_tail, n_fast_head, n_fast_tail, n_fast_tail2;

    logic [tqd_pkg::PHASE_W-1:0] r_slow_phase, r_medium_phase, r_fast_phase;

    logic [tqd_pkg::TASK_W-1:0] r_slow_rd, r_medium_rd, r_fast_rd;
    logic                       r_refused, r_dispatched;
    logic [tqd_pkg::TASK_W-1:0] r_out_task;
    logic                       r_out_refused, r_out_dispatched;

    logic slow_full, medium_full, fast_full, pair_room;
    logic slow_empty, medium_empty, fast_empty;
    logic is_push_slow, is_push_medium, is_push_fast, is_pair;
    logic is_tick_slow, is_tick_medium, is_tick_fast;
    logic wr_slow, wr_medium, wr_fast;
    logic pop_slow, pop_medium, pop_fast;
    logic n_refused;
    logic [tqd_pkg::TASK_W-1:0] rd_sel;

    // wrap-around successors of each pointer
    assign n_slow_head   = (r_slow_head == SW'(SLOW_DEPTH - 1)) ? '0 : r_slow_head + 1'b1;
    assign n_slow_tail   = (r_slow_tail == SW'(SLOW_DEPTH - 1)) ? '0 : r_slow_tail + 1'b1;
    assign n_medium_head = (r_medium_head == MW'(MEDIUM_DEPTH - 1)) ? '0
                                                                    : r_medium_head + 1'b1;
    assign n_medium_tail = (r_medium_tail == MW'(MEDIUM_DEPTH - 1)) ? '0
                                                                    : r_medium_tail + 1'b1;
    assign n_fast_head   = (r_fast_head == FW'(FAST_DEPTH - 1)) ? '0 : r_fast_head + 1'b1;
    assign n_fast_tail   = (r_fast_tail == FW'(FAST_DEPTH - 1)) ? '0 : r_fast_tail + 1'b1;
    assign n_fast_tail2  = (n_fast_tail == FW'(FAST_DEPTH - 1)) ? '0 : n_fast_tail + 1'b1;

    // one slot always kept empty
    assign slow_full    = (n_slow_tail == r_slow_head);
    assign medium_full  = (n_medium_tail == r_medium_head);
    assign fast_full    = (n_fast_tail == r_fast_head);
    assign pair_room    = !fast_full && (n_fast_tail2 != r_fast_head);
    assign slow_empty   = (r_slow_head == r_slow_tail);
    assign medium_empty = (r_medium_head == r_medium_tail);
    assign fast_empty   = (r_fast_head == r_fast_tail);

    assign is_push_slow   = (r_action == tqd_pkg::ACT_PUSH_SLOW);
    assign is_push_medium = (r_action == tqd_pkg::ACT_PUSH_MEDIUM);
    assign is_push_fast   = (r_action == tqd_pkg::ACT_PUSH_FAST);
    assign is_pair        = (r_action == tqd_pkg::ACT_PUSH_PAIR);
    assign is_tick_slow   = (r_action == tqd_pkg::ACT_TICK_SLOW);
    assign is_tick_medium = (r_action == tqd_pkg::ACT_TICK_MEDIUM);
    assign is_tick_fast   = (r_action == tqd_pkg::ACT_TICK_FAST);

    assign wr_slow   = i_cmd.execute && is_push_slow && !slow_full;
    assign wr_medium = i_cmd.execute && is_push_medium && !medium_full;
    assign wr_fast   = (i_cmd.execute && ((is_push_fast && !fast_full) ||
                                          (is_pair && pair_room))) ||
                       i_cmd.write_second;

    // slow/medium fire off phase zero, fast only on phase zero
    assign pop_slow   = i_cmd.execute && is_tick_slow && (r_slow_phase != '0) && !slow_empty;
    assign pop_medium = i_cmd.execute && is_tick_medium && (r_medium_phase != '0)
                        && !medium_empty;
    assign pop_fast   = i_cmd.execute && is_tick_fast && (r_fast_phase == '0) && !fast_empty;

    assign n_refused = (is_push_slow && slow_full) || (is_push_medium && medium_full) ||
                       (is_push_fast && fast_full) || (is_pair && !pair_room);

    assign o_sts.pair_go = is_pair && pair_room;

    always_comb begin
        case (r_action)
            tqd_pkg::ACT_TICK_SLOW:   rd_sel = r_slow_rd;
            tqd_pkg::ACT_TICK_MEDIUM: rd_sel = r_medium_rd;
            default:                  rd_sel = r_fast_rd;
        endcase
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr_slow) begin
            r_slow_mem[r_slow_tail] <= r_task1;
        end
        if (i_cmd.execute) begin
            r_slow_rd <= r_slow_mem[r_slow_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_medium) begin
            r_medium_mem[r_medium_tail] <= r_task1;
        end
        if (i_cmd.execute) begin
            r_medium_rd <= r_medium_mem[r_medium_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_fast) begin
            r_fast_mem[r_fast_tail] <= i_cmd.write_second ? r_task2 : r_task1;
        end
        if (i_cmd.execute) begin
            r_fast_rd <= r_fast_mem[r_fast_head];
        end
    end

    // item capture and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= i_action;
            r_task1  <= i_task_req;
            r_task2  <= i_second_task;
        end
        if (i_cmd.execute) begin
            r_refused    <= n_refused;
            r_dispatched <= pop_slow || pop_medium || pop_fast;
        end
        if (i_cmd.load_result) begin
            r_out_refused    <= r_refused;
            r_out_dispatched <= r_dispatched;
            r_out_task       <= r_dispatched ? rd_sel : '0;
        end
    end

    // pointers and phase counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_head    <= '0;
            r_slow_tail    <= '0;
            r_medium_head  <= '0;
            r_medium_tail  <= '0;
            r_fast_head    <= '0;
            r_fast_tail    <= '0;
            r_slow_phase   <= '0;
            r_medium_phase <= '0;
            r_fast_phase   <= '0;
        end else begin
            if (wr_slow)    r_slow_tail   <= n_slow_tail;
            if (wr_medium)  r_medium_tail <= n_medium_tail;
            if (wr_fast)    r_fast_tail   <= n_fast_tail;
            if (pop_slow)   r_slow_head   <= n_slow_head;
            if (pop_medium) r_medium_head <= n_medium_head;
            if (pop_fast)   r_fast_head   <= n_fast_head;
            if (i_cmd.execute && is_tick_slow)   r_slow_phase   <= r_slow_phase + 1'b1;
            if (i_cmd.execute && is_tick_medium) r_medium_phase <= r_medium_phase + 1'b1;
            if (i_cmd.execute && is_tick_fast)   r_fast_phase   <= r_fast_phase + 1'b1;
        end
    end

    assign o_refused         = r_out_refused;
    assign o_dispatched      = r_out_dispatched;
    assign o_dispatched_task = r_out_task;

endmodule

// ----- rtl/three_queue_phased_task_dispatcher.sv -----
// Top level of the three-queue phased task dispatcher.
//
// Input stream (s_axis): one transaction per action. tuser[2:0] carries the
// action (push slow, medium, fast, fast pair, tick slow, medium, fast);
// tdata[7:0] the task number, tdata[15:8] the second task of a fast pair.
// Output stream (m_axis): exactly one result transaction per input.
// tuser[0] = refused, tuser[1] = dispatched, tdata[7:0] = task dispatched
// (zero when none).
// Sequence: an item is taken in the idle state, executed the next cycle
// (decision, first queue write or head read, phase step), a fast pair then
// does its second write in the pair state, then the result is loaded into the
// output register. tready returns the cycle after that load, so a new item is
// taken only once the result of the last one has been loaded.
// A stalled receiver holds the result register; the controller then waits
// with the following result until the register frees, and tready stays low.
// Reset (synchronous, active low) empties all queues and zeroes the phases;
// queue entries themselves are not cleared, nor need to be.
`include "three_queue_phased_task_dispatcher_macros.svh"

module three_queue_phased_task_dispatcher #(
    parameter int SLOW_DEPTH   = 16,
    parameter int MEDIUM_DEPTH = 16,
    parameter int FAST_DEPTH   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [7:0] task_req, [15:8] second_task
    input  logic [2:0]  i_s_axis_tuser,  // [2:0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // [7:0] dispatched_task
    output logic [1:0]  o_m_axis_tuser   // [0] refused, [1] dispatched
);

    tqd_pkg::t_cmd cmd;
    tqd_pkg::t_sts sts;
    logic          refused;
    logic          dispatched;
    logic          s_accept;
    logic          m_held;
    logic          m_empty_result;

    tqd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tqd_dp #(
        .SLOW_DEPTH   (SLOW_DEPTH),
        .MEDIUM_DEPTH (MEDIUM_DEPTH),
        .FAST_DEPTH   (FAST_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_action          (i_s_axis_tuser),
        .i_task_req        (i_s_axis_tdata[7:0]),
        .i_second_task     (i_s_axis_tdata[15:8]),
        .o_refused         (refused),
        .o_dispatched      (dispatched),
        .o_dispatched_task (o_m_axis_tdata)
    );

    assign o_m_axis_tuser = {dispatched, refused};

    // handshake terms for the checks below
    assign s_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign m_held         = o_m_axis_tvalid && !i_m_axis_tready;
    assign m_empty_result = o_m_axis_tvalid && !dispatched;

    // an accepted transaction is executed on the very next cycle
    `TQD_ASSERT_NEXT(a_accept_then_exec, i_clk, i_rst_n, s_accept, cmd.execute)
    // a new result never overwrites one still waiting on a stalled receiver
    `TQD_ASSERT_IMPLY(a_no_result_overrun, i_clk, i_rst_n, cmd.load_result, !m_held)
    // a transaction is either a push or a tick, never both outcomes
    `TQD_ASSERT_IMPLY(a_flags_exclusive, i_clk, i_rst_n, o_m_axis_tvalid, !(refused && dispatched))
    // task field is zero whenever nothing was dispatched
    `TQD_ASSERT_IMPLY(a_task_zero_idle, i_clk, i_rst_n, m_empty_result, o_m_axis_tdata == 8'd0)

endmodule
